// ----- rtl/gmpg_pkg.sv -----
`default_nettype none

package gmpg_pkg;

    localparam int CfgW    = 32;
    localparam int CountW  = 11;
    localparam int IdxW    = 10;
    localparam int PosW    = 32;
    localparam int TexW    = 17;
    localparam int CornerW = 20;
    localparam int TexFrac = 16;

    // divider geometry: 44-bit dividend, 12-bit divisor, 32 quotient bits
    localparam int NumW           = 44;
    localparam int RemW           = 12;
    localparam int QuotW          = 32;
    localparam int StepsPerStage  = 4;
    localparam int DivStages      = QuotW / StepsPerStage;
    localparam int Lanes          = 4;

    localparam int LaneX = 0;
    localparam int LaneZ = 1;
    localparam int LaneU = 2;
    localparam int LaneV = 3;

    localparam logic [1:0] RegPlaneWidth  = 2'd0;
    localparam logic [1:0] RegPlaneDepth  = 2'd1;
    localparam logic [1:0] RegRowCount    = 2'd2;
    localparam logic [1:0] RegColumnCount = 2'd3;

    localparam logic [CfgW-1:0]   ResetExtent = 32'd65536;
    localparam logic [CountW-1:0] MinCount    = 11'd2;

    typedef struct packed {
        logic [RemW-1:0]  rem;
        logic [QuotW-1:0] work;
    } t_lane;

    typedef struct packed {
        logic               point_valid;
        logic               quad_valid;
        logic               neg_x;
        logic               neg_z;
        logic [CornerW-1:0] corner_a;
        logic [CornerW-1:0] corner_c;
    } t_side;

    // restoring division, a few quotient bits per pipeline stage
    function automatic t_lane div_step(input t_lane l, input logic [RemW-1:0] v);
        t_lane       r;
        logic [RemW:0] t;
        r = l;
        for (int s = 0; s < StepsPerStage; s++) begin
            t = {r.rem, r.work[QuotW-1]};
            if (t >= {1'b0, v}) begin
                r.rem  = RemW'(t - {1'b0, v});
                r.work = {r.work[QuotW-2:0], 1'b1};
            end else begin
                r.rem  = t[RemW-1:0];
                r.work = {r.work[QuotW-2:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/grid_mesh_point_generator_core.sv -----
`default_nettype none

// grid mesh point generator
// input channel: drive i_row and i_column with start high; a transaction is
// taken at every rising edge where start is high and busy is low. busy stays
// low, so one point can enter on every clock.
// output channel: each result is shown for one cycle with o_strobe high,
// in input order. the receiver cannot stall; results are not held.
// throughput: one point per cycle. the pipeline consists of the restoring
// divider (four lanes, four quotient bits per stage, eight stages) plus an
// input stage, a multiply stage, a dividend stage and the output register.
// configuration: i_cfg_we with i_cfg_idx and i_cfg_data writes plane width,
// plane depth, row count and column count; write only while no point is in
// flight. counts are clamped to the range 2 to MAX_SIDE.
// reset: synchronous, active low; clears the pipeline valid bits and loads
// width and depth of one unit and two rows by two columns.
module grid_mesh_point_generator_core
    import gmpg_pkg::*;
#(
    parameter int MAX_SIDE = 1024
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      start,
    output logic                     busy,
    input  wire [IdxW-1:0]           i_row,
    input  wire [IdxW-1:0]           i_column,
    input  wire                      i_cfg_we,
    input  wire [1:0]                i_cfg_idx,
    input  wire [CfgW-1:0]           i_cfg_data,
    output logic                     o_strobe,
    output logic signed [PosW-1:0]   o_pos_x,
    output logic signed [PosW-1:0]   o_pos_z,
    output logic [TexW-1:0]          o_tex_u,
    output logic [TexW-1:0]          o_tex_v,
    output logic                     o_point_valid,
    output logic                     o_quad_valid,
    output logic [CornerW-1:0]       o_corner_a,
    output logic [CornerW-1:0]       o_corner_b,
    output logic [CornerW-1:0]       o_corner_c,
    output logic [CornerW-1:0]       o_corner_d,
    output logic [CornerW-1:0]       o_corner_e,
    output logic [CornerW-1:0]       o_corner_f
);

    localparam int ProdW = CfgW + CountW;

    function automatic logic [CountW-1:0] eff_count(input logic [CountW-1:0] c);
        logic [CountW-1:0] e;
        if (c < MinCount) begin
            e = MinCount;
        end else if (13'(c) > 13'(MAX_SIDE)) begin
            e = CountW'(MAX_SIDE);
        end else begin
            e = c;
        end
        return e;
    endfunction

    // configuration registers
    logic [CfgW-1:0]   r_plane_width;
    logic [CfgW-1:0]   r_plane_depth;
    logic [CountW-1:0] r_row_count;
    logic [CountW-1:0] r_column_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane_width  <= ResetExtent;
            r_plane_depth  <= ResetExtent;
            r_row_count    <= MinCount;
            r_column_count <= MinCount;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                RegPlaneWidth:  r_plane_width  <= i_cfg_data;
                RegPlaneDepth:  r_plane_depth  <= i_cfg_data;
                RegRowCount:    r_row_count    <= i_cfg_data[CountW-1:0];
                RegColumnCount: r_column_count <= i_cfg_data[CountW-1:0];
                default: ;
            endcase
        end
    end

    // derived grid constants
    logic [CountW-1:0] rows_eff;
    logic [CountW-1:0] cols_eff;
    logic [CountW-1:0] span_r;
    logic [CountW-1:0] span_c;
    logic [RemW-1:0]   lane_v [Lanes];

    always_comb begin
        rows_eff = eff_count(r_row_count);
        cols_eff = eff_count(r_column_count);
        span_r   = rows_eff - CountW'(1);
        span_c   = cols_eff - CountW'(1);
        lane_v[LaneX] = {span_c, 1'b0};
        lane_v[LaneU] = {span_c, 1'b0};
        lane_v[LaneZ] = {span_r, 1'b0};
        lane_v[LaneV] = {span_r, 1'b0};
    end

    assign busy = 1'b0;

    // stage 0: input register
    logic            r0_valid;
    logic [IdxW-1:0] r0_row;
    logic [IdxW-1:0] r0_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else begin
            r0_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r0_row <= i_row;
        r0_col <= i_column;
    end

    // stage 1: range checks, centre offsets, products
    logic [CountW-1:0] twice_i;
    logic [CountW-1:0] twice_j;
    logic [CountW-1:0] dx;
    logic [CountW-1:0] dz;
    logic              n_neg_x;
    logic              n_neg_z;
    logic              n_point_valid;
    logic              n_quad_valid;

    always_comb begin
        twice_i = {r0_row, 1'b0};
        twice_j = {r0_col, 1'b0};
        if (twice_j >= span_c) begin
            dx      = twice_j - span_c;
            n_neg_x = 1'b1;
        end else begin
            dx      = span_c - twice_j;
            n_neg_x = 1'b0;
        end
        if (twice_i >= span_r) begin
            dz      = twice_i - span_r;
            n_neg_z = 1'b0;
        end else begin
            dz      = span_r - twice_i;
            n_neg_z = 1'b1;
        end
        n_point_valid = (CountW'(r0_row) < rows_eff) && (CountW'(r0_col) < cols_eff);
        n_quad_valid  = n_point_valid && (CountW'(r0_row) < span_r)
                        && (CountW'(r0_col) < span_c);
    end

    logic               r1_valid;
    logic [ProdW-1:0]   r1_prod_x;
    logic [ProdW-1:0]   r1_prod_z;
    logic [CornerW-1:0] r1_prod_i;
    logic [IdxW-1:0]    r1_row;
    logic [IdxW-1:0]    r1_col;
    logic               r1_point_valid;
    logic               r1_quad_valid;
    logic               r1_neg_x;
    logic               r1_neg_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= r0_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_prod_x      <= ProdW'(r_plane_width) * ProdW'(dx);
        r1_prod_z      <= ProdW'(r_plane_depth) * ProdW'(dz);
        r1_prod_i      <= CornerW'(CornerW'(r0_row) * CornerW'(cols_eff));
        r1_row         <= r0_row;
        r1_col         <= r0_col;
        r1_point_valid <= n_point_valid;
        r1_quad_valid  <= n_quad_valid;
        r1_neg_x       <= n_neg_x;
        r1_neg_z       <= n_neg_z;
    end

    // stage 2: dividends and corner bases, then divider stages
    logic [NumW-1:0]    num [Lanes];
    t_side              n_side;
    t_lane              r_div [DivStages+1][Lanes];
    t_side              r_dside [DivStages+1];
    logic [DivStages:0] r_dvalid;

    always_comb begin
        num[LaneX] = NumW'(r1_prod_x) + NumW'(span_c);
        num[LaneZ] = NumW'(r1_prod_z) + NumW'(span_r);
        num[LaneU] = NumW'({r1_col, {(TexFrac+1){1'b0}}}) + NumW'(span_c);
        num[LaneV] = NumW'({r1_row, {(TexFrac+1){1'b0}}}) + NumW'(span_r);
        n_side.point_valid = r1_point_valid;
        n_side.quad_valid  = r1_quad_valid;
        n_side.neg_x       = r1_neg_x;
        n_side.neg_z       = r1_neg_z;
        n_side.corner_a    = r1_prod_i + CornerW'(r1_col);
        n_side.corner_c    = r1_prod_i + CornerW'(r1_col) + CornerW'(cols_eff);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dvalid <= '0;
        end else begin
            r_dvalid <= {r_dvalid[DivStages-1:0], r1_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < Lanes; l++) begin
            r_div[0][l].rem  <= num[l][NumW-1:QuotW];
            r_div[0][l].work <= num[l][QuotW-1:0];
        end
        r_dside[0] <= n_side;
        for (int k = 1; k <= DivStages; k++) begin
            for (int l = 0; l < Lanes; l++) begin
                r_div[k][l] <= div_step(r_div[k-1][l], lane_v[l]);
            end
            r_dside[k] <= r_dside[k-1];
        end
    end

    // output register: signs, masking, zeroing
    t_side            fin_side;
    logic [QuotW-1:0] q_x;
    logic [QuotW-1:0] q_z;
    logic [QuotW-1:0] q_u;
    logic [QuotW-1:0] q_v;

    always_comb begin
        fin_side = r_dside[DivStages];
        q_x = r_div[DivStages][LaneX].work;
        q_z = r_div[DivStages][LaneZ].work;
        q_u = r_div[DivStages][LaneU].work;
        q_v = r_div[DivStages][LaneV].work;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= r_dvalid[DivStages];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!fin_side.point_valid) begin
            o_pos_x <= '0;
            o_pos_z <= '0;
            o_tex_u <= '0;
            o_tex_v <= '0;
        end else begin
            o_pos_x <= fin_side.neg_x ? PosW'(PosW'(0) - q_x) : q_x;
            o_pos_z <= fin_side.neg_z ? PosW'(PosW'(0) - q_z) : q_z;
            o_tex_u <= q_u[TexW-1:0];
            o_tex_v <= q_v[TexW-1:0];
        end
        o_point_valid <= fin_side.point_valid;
        o_quad_valid  <= fin_side.quad_valid;
        if (!fin_side.quad_valid) begin
            o_corner_a <= '0;
            o_corner_b <= '0;
            o_corner_c <= '0;
            o_corner_d <= '0;
            o_corner_e <= '0;
            o_corner_f <= '0;
        end else begin
            o_corner_a <= fin_side.corner_a;
            o_corner_b <= fin_side.corner_a + CornerW'(1);
            o_corner_c <= fin_side.corner_c;
            o_corner_d <= fin_side.corner_c;
            o_corner_e <= fin_side.corner_a + CornerW'(1);
            o_corner_f <= fin_side.corner_c + CornerW'(1);
        end
    end

`ifndef SYNTHESIS
    a_latency_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##12 o_strobe)
        else $error("result missing after input transaction");

    a_latency_bwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy && i_rst_n, 12))
        else $error("result without input transaction");

    a_quad_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_quad_valid) |-> o_point_valid)
        else $error("quad flagged outside grid");

    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_point_valid) |-> (o_pos_x == 0 && o_pos_z == 0
            && o_tex_u == 0 && o_tex_v == 0 && o_corner_a == 0))
        else $error("point outside grid with nonzero fields");
`endif

endmodule

`default_nettype wire

// ----- test/grid_point_checker.sv -----
`timescale 1ns / 100ps

module grid_point_checker
    import gmpg_pkg::*;
#(
    parameter int MAX_SIDE = 1024
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_start,
    input  wire                     i_busy,
    input  wire [IdxW-1:0]          i_row,
    input  wire [IdxW-1:0]          i_column,
    input  wire                     i_cfg_we,
    input  wire [1:0]               i_cfg_idx,
    input  wire [CfgW-1:0]          i_cfg_data,
    input  wire                     i_strobe,
    input  wire signed [PosW-1:0]   i_pos_x,
    input  wire signed [PosW-1:0]   i_pos_z,
    input  wire [TexW-1:0]          i_tex_u,
    input  wire [TexW-1:0]          i_tex_v,
    input  wire                     i_point_valid,
    input  wire                     i_quad_valid,
    input  wire [CornerW-1:0]       i_corner_a,
    input  wire [CornerW-1:0]       i_corner_b,
    input  wire [CornerW-1:0]       i_corner_c,
    input  wire [CornerW-1:0]       i_corner_d,
    input  wire [CornerW-1:0]       i_corner_e,
    input  wire [CornerW-1:0]       i_corner_f,
    output int                      o_fail_count,
    output int                      o_pending
);

    typedef struct packed {
        logic [PosW-1:0]    pos_x;
        logic [PosW-1:0]    pos_z;
        logic [TexW-1:0]    tex_u;
        logic [TexW-1:0]    tex_v;
        logic               point_valid;
        logic               quad_valid;
        logic [CornerW-1:0] corner_a;
        logic [CornerW-1:0] corner_b;
        logic [CornerW-1:0] corner_c;
        logic [CornerW-1:0] corner_d;
        logic [CornerW-1:0] corner_e;
        logic [CornerW-1:0] corner_f;
    } t_vertex;

    logic [CfgW-1:0]   width_reg;
    logic [CfgW-1:0]   depth_reg;
    logic [CountW-1:0] rows_reg;
    logic [CountW-1:0] cols_reg;
    t_vertex           vertex_q[$];
    int                mismatches = 0;

    function automatic logic [63:0] side_clamp(input logic [CountW-1:0] c);
        if (c < MinCount) return 64'd2;
        if (c > MAX_SIDE) return 64'(MAX_SIDE);
        return 64'(c);
    endfunction

    // extent * (2*idx - span) / (2*span), negated when flip is set, rounded on the magnitude
    function automatic logic [PosW-1:0] centred_pos(input logic [CfgW-1:0] extent,
                                                    input logic [63:0] idx,
                                                    input logic [63:0] span,
                                                    input bit flip);
        logic [63:0] twice;
        logic [63:0] diff;
        logic [63:0] den;
        logic [63:0] q;
        bit          neg;
        twice = 64'd2 * idx;
        den   = 64'd2 * span;
        if (twice >= span) begin
            diff = twice - span;
            neg  = 1'b0;
        end else begin
            diff = span - twice;
            neg  = 1'b1;
        end
        neg = neg ^ flip;
        q = (64'd2 * {32'd0, extent} * diff + den) / (64'd2 * den);
        if (neg) q = 64'd0 - q;
        return q[PosW-1:0];
    endfunction

    function automatic logic [TexW-1:0] tex_ratio(input logic [63:0] idx,
                                                  input logic [63:0] span);
        logic [63:0] q;
        q = (idx * 64'd131072 + span) / (64'd2 * span);
        return q[TexW-1:0];
    endfunction

    function automatic t_vertex predict_vertex(input logic [IdxW-1:0] row,
                                               input logic [IdxW-1:0] col);
        t_vertex     v;
        logic [63:0] i;
        logic [63:0] j;
        logic [63:0] m;
        logic [63:0] n;
        logic [63:0] a;
        logic [63:0] c;
        v = '0;
        i = 64'(row);
        j = 64'(col);
        m = side_clamp(rows_reg);
        n = side_clamp(cols_reg);
        if (i < m && j < n) begin
            v.pos_x       = centred_pos(width_reg, j, n - 64'd1, 1'b1);
            v.pos_z       = centred_pos(depth_reg, i, m - 64'd1, 1'b0);
            v.tex_u       = tex_ratio(j, n - 64'd1);
            v.tex_v       = tex_ratio(i, m - 64'd1);
            v.point_valid = 1'b1;
            if (i < m - 64'd1 && j < n - 64'd1) begin
                a = i * n + j;
                c = (i + 64'd1) * n + j;
                v.quad_valid = 1'b1;
                v.corner_a   = a[CornerW-1:0];
                v.corner_b   = 20'(a + 64'd1);
                v.corner_c   = c[CornerW-1:0];
                v.corner_d   = c[CornerW-1:0];
                v.corner_e   = 20'(a + 64'd1);
                v.corner_f   = 20'(c + 64'd1);
            end
        end
        return v;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%h, got 0x%h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_vertex want;
        if (!i_rst_n) begin
            width_reg = ResetExtent;
            depth_reg = ResetExtent;
            rows_reg  = MinCount;
            cols_reg  = MinCount;
            vertex_q.delete();
        end else begin
            if (i_strobe) begin
                if (vertex_q.size() == 0) begin
                    $error("result transaction with no expected vertex waiting");
                    mismatches++;
                end else begin
                    want = vertex_q.pop_front();
                    compare_field("pos_x", want.pos_x, i_pos_x);
                    compare_field("pos_z", want.pos_z, i_pos_z);
                    compare_field("tex_u", want.tex_u, i_tex_u);
                    compare_field("tex_v", want.tex_v, i_tex_v);
                    compare_field("point_valid", want.point_valid, i_point_valid);
                    compare_field("quad_valid", want.quad_valid, i_quad_valid);
                    compare_field("corner_a", want.corner_a, i_corner_a);
                    compare_field("corner_b", want.corner_b, i_corner_b);
                    compare_field("corner_c", want.corner_c, i_corner_c);
                    compare_field("corner_d", want.corner_d, i_corner_d);
                    compare_field("corner_e", want.corner_e, i_corner_e);
                    compare_field("corner_f", want.corner_f, i_corner_f);
                end
            end
            if (i_start && !i_busy) begin
                vertex_q.insert(vertex_q.size(), predict_vertex(i_row, i_column));
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    RegPlaneWidth:  width_reg = i_cfg_data;
                    RegPlaneDepth:  depth_reg = i_cfg_data;
                    RegRowCount:    rows_reg  = i_cfg_data[CountW-1:0];
                    RegColumnCount: cols_reg  = i_cfg_data[CountW-1:0];
                    default: ;
                endcase
            end
        end
        o_pending    <= vertex_q.size();
        o_fail_count <= mismatches;
    end

endmodule

// ----- test/grid_mesh_point_generator_core_tb.sv -----
`timescale 1ns / 100ps

module grid_mesh_point_generator_core_tb;
    import gmpg_pkg::*;

    localparam int MaxSide    = 1024;
    localparam int CycleLimit = 200000;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic [IdxW-1:0]          i_row = '0;
    logic [IdxW-1:0]          i_column = '0;
    logic                     i_cfg_we = 1'b0;
    logic [1:0]               i_cfg_idx = RegPlaneWidth;
    logic [CfgW-1:0]          i_cfg_data = '0;
    logic                     o_strobe;
    logic signed [PosW-1:0]   o_pos_x;
    logic signed [PosW-1:0]   o_pos_z;
    logic [TexW-1:0]          o_tex_u;
    logic [TexW-1:0]          o_tex_v;
    logic                     o_point_valid;
    logic                     o_quad_valid;
    logic [CornerW-1:0]       o_corner_a;
    logic [CornerW-1:0]       o_corner_b;
    logic [CornerW-1:0]       o_corner_c;
    logic [CornerW-1:0]       o_corner_d;
    logic [CornerW-1:0]       o_corner_e;
    logic [CornerW-1:0]       o_corner_f;

    int fail_count;
    int pending_count;
    int cycle_count = 0;
    int idle_pct = 30;
    int rows_eff = 2;
    int cols_eff = 2;

    always #4 i_clk = ~i_clk;

    grid_mesh_point_generator_core #(
        .MAX_SIDE(MaxSide)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_row(i_row),
        .i_column(i_column),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .o_strobe(o_strobe),
        .o_pos_x(o_pos_x),
        .o_pos_z(o_pos_z),
        .o_tex_u(o_tex_u),
        .o_tex_v(o_tex_v),
        .o_point_valid(o_point_valid),
        .o_quad_valid(o_quad_valid),
        .o_corner_a(o_corner_a),
        .o_corner_b(o_corner_b),
        .o_corner_c(o_corner_c),
        .o_corner_d(o_corner_d),
        .o_corner_e(o_corner_e),
        .o_corner_f(o_corner_f)
    );

    grid_point_checker #(
        .MAX_SIDE(MaxSide)
    ) checker_inst (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_busy(busy),
        .i_row(i_row),
        .i_column(i_column),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_strobe(o_strobe),
        .i_pos_x(o_pos_x),
        .i_pos_z(o_pos_z),
        .i_tex_u(o_tex_u),
        .i_tex_v(o_tex_v),
        .i_point_valid(o_point_valid),
        .i_quad_valid(o_quad_valid),
        .i_corner_a(o_corner_a),
        .i_corner_b(o_corner_b),
        .i_corner_c(o_corner_c),
        .i_corner_d(o_corner_d),
        .i_corner_e(o_corner_e),
        .i_corner_f(o_corner_f),
        .o_fail_count(fail_count),
        .o_pending(pending_count)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic int eff_side(input logic [CfgW-1:0] data);
        if (data[CountW-1:0] < MinCount) return 2;
        if (data[CountW-1:0] > MaxSide) return MaxSide;
        return int'(data[CountW-1:0]);
    endfunction

    function automatic logic [CfgW-1:0] rand_extent();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0) return '0;
        if (pick == 1) return '1;
        return $urandom();
    endfunction

    function automatic logic [CfgW-1:0] rand_count();
        int pick;
        pick = $urandom_range(99);
        if (pick < 60) return $urandom_range(40, 2);
        if (pick < 85) return $urandom_range(MaxSide, 41);
        return $urandom();
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [CfgW-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [CfgW-1:0] w, input logic [CfgW-1:0] d,
                             input logic [CfgW-1:0] r, input logic [CfgW-1:0] c);
        write_reg(RegPlaneWidth, w);
        write_reg(RegPlaneDepth, d);
        write_reg(RegRowCount, r);
        write_reg(RegColumnCount, c);
        i_cfg_we <= 1'b0;
        rows_eff = eff_side(r);
        cols_eff = eff_side(c);
    endtask

    task automatic send_point(input logic [IdxW-1:0] r, input logic [IdxW-1:0] c);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start    <= 1'b1;
        i_row    <= r;
        i_column <= c;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // stop sending and let every outstanding transaction come back
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic random_point();
        logic [IdxW-1:0] r;
        logic [IdxW-1:0] c;
        int              pick;
        pick = $urandom_range(99);
        if (pick < 70) begin
            r = IdxW'($urandom_range(rows_eff - 1));
            c = IdxW'($urandom_range(cols_eff - 1));
        end else if (pick < 85) begin
            // last row or last column: point exists, quad does not
            if ($urandom_range(1)) begin
                r = IdxW'(rows_eff - 1);
                c = IdxW'($urandom_range(cols_eff - 1));
            end else begin
                r = IdxW'($urandom_range(rows_eff - 1));
                c = IdxW'(cols_eff - 1);
            end
        end else begin
            r = IdxW'($urandom_range(1023));
            c = IdxW'($urandom_range(1023));
        end
        send_point(r, c);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset grid: two by two, unit extents
        send_point(10'd0, 10'd0);
        send_point(10'd0, 10'd1);
        send_point(10'd1, 10'd0);
        send_point(10'd1, 10'd1);
        send_point(10'd2, 10'd0);
        send_point(10'd0, 10'd2);

        // largest grid, extreme extents
        drain();
        configure(32'hFFFF_FFFF, 32'd0, 32'd1024, 32'd1024);
        send_point(10'd0, 10'd0);
        send_point(10'd1023, 10'd1023);
        send_point(10'd1022, 10'd1022);
        send_point(10'd1023, 10'd0);
        send_point(10'd0, 10'd1023);
        send_point(10'd511, 10'd512);

        // counts out of range clamp to two and to the maximum
        drain();
        configure(32'd3, 32'h0001_8001, 32'hFFFF_F800, 32'd2047);
        send_point(10'd0, 10'd0);
        send_point(10'd1, 10'd1023);
        send_point(10'd2, 10'd5);
        send_point(10'd1, 10'd1022);

        // odd sizes for rounding ties
        drain();
        configure(32'd5, 32'd7, 32'd3, 32'd5);
        send_point(10'd1, 10'd2);
        send_point(10'd2, 10'd4);
        send_point(10'd0, 10'd3);
        send_point(10'd1, 10'd1);
        send_point(10'd3, 10'd0);

        for (int p = 0; p < 10; p++) begin
            drain();
            configure(rand_extent(), rand_extent(), rand_count(), rand_count());
            idle_pct = (p == 2) ? 0 : 30;
            for (int k = 0; k < 85; k++) begin
                if (p == 5 && k == 40) drain();
                random_point();
            end
        end

        drain();
        repeat (16) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/gmpg_pkg.sv
rtl/grid_mesh_point_generator_core.sv
test/grid_point_checker.sv
test/grid_mesh_point_generator_core_tb.sv
